/* rtl/core/p24_pkg.sv */
// ----------------------------------------------------------------------------
// p24_pkg: shared types, constants and round functions for PRESENT-24
// Holds the 4-bit S-box, the substitution and permutation layers and the
// 80-bit key register update that every round cell uses.
// ----------------------------------------------------------------------------
package p24_pkg;

  localparam int BLOCK_W         = 24;
  localparam int KEY_IN_W        = 24;
  localparam int KEY_REG_W       = 80;
  localparam int CTR_W           = 5;
  localparam int ROUND_COUNT_DEF = 10;

  typedef logic [BLOCK_W-1:0]   block_t;
  typedef logic [KEY_IN_W-1:0]  master_key_t;
  typedef logic [KEY_REG_W-1:0] key_reg_t;
  typedef logic [CTR_W-1:0]     ctr_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    return SBOX[x];
  endfunction

  function automatic block_t sub_layer(input block_t x);
    block_t r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox4(x[4*n +: 4]);
    end
    return r;
  endfunction

  // Bit i moves to bit 6*i mod 23; the top bit stays where it is.
  function automatic block_t perm_layer(input block_t x);
    block_t r;
    r = '0;
    r[BLOCK_W-1] = x[BLOCK_W-1];
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      r[(6 * i) % (BLOCK_W - 1)] = x[i];
    end
    return r;
  endfunction

  function automatic block_t subkey_of(input key_reg_t k);
    return k[39:16];
  endfunction

  // Rotate left by 61, S-box on the top nibble, round counter into bits 19..15.
  function automatic key_reg_t key_update(input key_reg_t k, input ctr_t ctr);
    key_reg_t n;
    n = {k[18:0], k[79:19]};
    n[79:76] = sbox4(n[79:76]);
    n[19:15] = n[19:15] ^ ctr;
    return n;
  endfunction

  function automatic key_reg_t key_load(input master_key_t mk);
    return {mk, {(KEY_REG_W - KEY_IN_W){1'b0}}};
  endfunction

endpackage

/* rtl/core/p24_round_cell.sv */
// ----------------------------------------------------------------------------
// p24_round_cell: one PRESENT-24 round
// Takes block and key register from the previous cell, applies one round and
// one key schedule step, and registers the result for the next cell.
// ----------------------------------------------------------------------------
module p24_round_cell #(
  parameter int ROUND = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_in,
  input  p24_pkg::block_t   state_in,
  input  p24_pkg::key_reg_t key_in,
  output logic              valid_out,
  output p24_pkg::block_t   state_out,
  output p24_pkg::key_reg_t key_out
);
  import p24_pkg::*;

  localparam ctr_t ROUND_CTR = ctr_t'(ROUND);

  logic     valid_r;
  block_t   state_r, state_nxt;
  key_reg_t key_r, key_nxt;

  always_comb begin
    state_nxt = perm_layer(sub_layer(state_in ^ subkey_of(key_in)));
    key_nxt   = key_update(key_in, ROUND_CTR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign valid_out = valid_r;
  assign state_out = state_r;
  assign key_out   = key_r;

endmodule

/* rtl/core/present24_block_encrypt_top.sv */
// ----------------------------------------------------------------------------
// present24_block_encrypt_top: pipelined PRESENT-24 encryption
// A row of round cells, one per round, followed by the final subkey XOR.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+------------------
//   request   | start, busy, in_plaintext, in_master_key | start && !busy
//   result    | out_valid, out_ciphertext               | one-cycle strobe
//
// A new request is taken every cycle; busy is always low.
// A request passes one register per round cell and one
// output register for the final key XOR.
// Reset clears the valid bits of the cells and the output strobe only.
// The receiver cannot stall, so results leave on the strobe cycle.
// ----------------------------------------------------------------------------
module present24_block_encrypt_top #(
  parameter int ROUND_COUNT = p24_pkg::ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  p24_pkg::block_t       in_plaintext,
  input  p24_pkg::master_key_t  in_master_key,
  output logic                  out_valid,
  output p24_pkg::block_t       out_ciphertext
);
  import p24_pkg::*;

  logic     stg_valid [ROUND_COUNT+1];
  block_t   stg_state [ROUND_COUNT+1];
  key_reg_t stg_key   [ROUND_COUNT+1];

  logic   out_valid_r;
  block_t ciphertext_r, ciphertext_nxt;

  assign busy         = 1'b0;
  assign stg_valid[0] = start && !busy;
  assign stg_state[0] = in_plaintext;
  assign stg_key[0]   = key_load(in_master_key);

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    p24_round_cell #(
      .ROUND(g + 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (stg_valid[g]),
      .state_in (stg_state[g]),
      .key_in   (stg_key[g]),
      .valid_out(stg_valid[g+1]),
      .state_out(stg_state[g+1]),
      .key_out  (stg_key[g+1])
    );
  end

  assign ciphertext_nxt = stg_state[ROUND_COUNT] ^ subkey_of(stg_key[ROUND_COUNT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    ciphertext_r <= ciphertext_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = ciphertext_r;

  // Every accepted request gives a result strobe after every round cell and the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ROUND_COUNT + 1) out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(stg_valid[0], ROUND_COUNT + 1))
    else $error("result strobe without a matching request");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[ROUND_COUNT] |=> out_valid)
    else $error("last round cell output was dropped");

endmodule
